// File: rtl/lru_verdict_cache_assert.svh
// assertion macros for the verdict cache checker
// depends on nothing; taken in by lvc_checker.sv
`ifndef LRU_VERDICT_CACHE_ASSERT_SVH
`define LRU_VERDICT_CACHE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define LVC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define LVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/lvc_pkg.sv
// shared types and codes for the verdict cache
// used by lvc_ctrl, lvc_dp, the top level and the checker
`timescale 1ns / 1ps

package lvc_pkg;

  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_FLUSH  = 2'd2;

  localparam logic [1:0] STAT_NONE    = 2'd0;
  localparam logic [1:0] STAT_VALID   = 2'd1;
  localparam logic [1:0] STAT_MISSING = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic ld_in;
    logic cmp;
    logic upd;
  } cmd_t;

endpackage

// File: rtl/lvc_ctrl.sv
// controller state machine for the verdict cache
// depends on lvc_pkg; drives lvc_dp through lvc_pkg::cmd_t
`timescale 1ns / 1ps

module lvc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output lvc_pkg::cmd_t cmd
);

  lvc_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lvc_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = lvc_pkg::ST_CMP;
      end
      lvc_pkg::ST_CMP: begin
        state_nxt = lvc_pkg::ST_UPD;
      end
      lvc_pkg::ST_UPD: begin
        if (out_free) state_nxt = in_valid ? lvc_pkg::ST_CMP : lvc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lvc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      lvc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      lvc_pkg::ST_CMP: begin
        cmd.cmp = 1'b1;
      end
      lvc_pkg::ST_UPD: begin
        in_ready = out_free;
        cmd.upd  = out_free;
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd.ld_in = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lvc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/lvc_dp.sv
// datapath of the verdict cache: entry row, parallel compare, shift update
// depends on lvc_pkg; commanded by lvc_ctrl
`timescale 1ns / 1ps

module lvc_dp #(
  parameter int CACHE_ENTRIES = 40,
  parameter int KEY_BITS      = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  lvc_pkg::cmd_t cmd,
  input  logic [1:0]    in_action,
  input  logic [63:0]   in_key,
  input  logic          in_verdict,
  output logic [1:0]    out_status
);

  localparam int FW = $clog2(CACHE_ENTRIES + 1);
  localparam logic [FW-1:0] FULL = FW'(CACHE_ENTRIES);
  localparam logic [FW-1:0] TOP  = FW'(CACHE_ENTRIES - 1);

  logic [KEY_BITS-1:0]      key_mem_r [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] vrd_mem_r;
  logic [KEY_BITS-1:0]      up_key [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] up_vrd;

  logic [1:0]               act_r;
  logic [KEY_BITS-1:0]      key_r;
  logic                     vrd_r;
  logic [FW-1:0]            fill_r, fill_nxt;
  logic [CACHE_ENTRIES-1:0] hit_r, hit_nxt;
  logic [1:0]               stat_r, stat_nxt;
  logic [1:0]               out_status_r;

  logic [CACHE_ENTRIES-1:0] ge_hit;
  logic                     present;
  logic                     new_vrd;
  logic [FW-1:0]            wr_idx;
  logic                     shift_all;

  assign out_status = out_status_r;

  // neighbor above each entry, the new key sits above the top entry
  for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_up
    if (g < CACHE_ENTRIES - 1) begin : g_mid
      assign up_key[g] = key_mem_r[g+1];
      assign up_vrd[g] = vrd_mem_r[g+1];
    end else begin : g_top
      assign up_key[g] = key_r;
      assign up_vrd[g] = vrd_r;
    end
  end

  // parallel compare against valid entries, keys are unique so at most one hit
  always_comb begin
    hit_nxt = '0;
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      hit_nxt[i] = (FW'(i) < fill_r) && (key_mem_r[i] == key_r);
    end
    if (hit_nxt == '0) stat_nxt = lvc_pkg::STAT_NONE;
    else if ((hit_nxt & vrd_mem_r) != '0) stat_nxt = lvc_pkg::STAT_MISSING;
    else stat_nxt = lvc_pkg::STAT_VALID;
  end

  // entries at or above the hit
  always_comb begin
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      ge_hit[i] = |(hit_r & ({CACHE_ENTRIES{1'b1}} >> (CACHE_ENTRIES - 1 - i)));
    end
  end

  always_comb begin
    present   = |hit_r;
    new_vrd   = present ? (stat_r == lvc_pkg::STAT_MISSING) : vrd_r;
    shift_all = !present && (fill_r == FULL);
    if (present) wr_idx = fill_r - FW'(1);
    else if (fill_r == FULL) wr_idx = TOP;
    else wr_idx = fill_r;
    fill_nxt = fill_r;
    if (cmd.upd) begin
      if (act_r == lvc_pkg::ACT_FLUSH) fill_nxt = '0;
      else if (act_r == lvc_pkg::ACT_INSERT && !present && fill_r != FULL)
        fill_nxt = fill_r + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      act_r <= in_action;
      key_r <= in_key[KEY_BITS-1:0];
      vrd_r <= in_verdict;
    end
    if (cmd.cmp) begin
      hit_r  <= hit_nxt;
      stat_r <= stat_nxt;
    end
    if (cmd.upd) begin
      out_status_r <= stat_r;
      if (act_r == lvc_pkg::ACT_INSERT) begin
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
          if (FW'(i) == wr_idx) begin
            key_mem_r[i] <= key_r;
            vrd_mem_r[i] <= new_vrd;
          end else if ((FW'(i) < wr_idx) && (shift_all || (present && ge_hit[i]))) begin
            key_mem_r[i] <= up_key[i];
            vrd_mem_r[i] <= up_vrd[i];
          end
        end
      end
    end
  end

endmodule

// File: rtl/lru_verdict_cache.sv
// verdict cache top level: lvc_ctrl and lvc_dp, depends on lvc_pkg
// an item passes the compare state; the update state then registers its result
// a new item is accepted only when idle or in the update state of the last one
// a held result stalls the update cycle until the output register is free
// reset empties the cache (fill count zero) and clears the output valid
`timescale 1ns / 1ps

module lru_verdict_cache #(
  parameter int CACHE_ENTRIES = 40,
  parameter int KEY_BITS      = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [63:0] in_key,
  input  logic        in_verdict,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status
);

  lvc_pkg::cmd_t cmd;

  lvc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lvc_dp #(
    .CACHE_ENTRIES (CACHE_ENTRIES),
    .KEY_BITS      (KEY_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_action  (in_action),
    .in_key     (in_key),
    .in_verdict (in_verdict),
    .out_status (out_status)
  );

endmodule

// File: rtl/lvc_checker.sv
// port checker for the verdict cache, bound to the top level
// depends on lvc_pkg and lru_verdict_cache_assert.svh
`timescale 1ns / 1ps
`include "lru_verdict_cache_assert.svh"

module lvc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status
);

  // held result keeps its value
  `LVC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status))
  // only defined status codes leave the block
  `LVC_ASSERT_SAME(a_stat_code, clk, rst_n, out_valid, out_status == lvc_pkg::STAT_NONE || out_status == lvc_pkg::STAT_VALID || out_status == lvc_pkg::STAT_MISSING)
  // one item at a time: no accept in the cycle after an accept
  `LVC_ASSERT_NEXT(a_no_overlap, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind lru_verdict_cache lvc_checker u_chk (.*);

// File: test/tb_lru_verdict_cache.sv
// testbench for lru_verdict_cache: queue-fed driver, checking monitor, in-bench lru predictor
// depends on lvc_pkg and the lru_verdict_cache rtl
`timescale 1ns / 1ps

module tb_lru_verdict_cache;
  import lvc_pkg::*;

  localparam int CACHE_ENTRIES = 40;
  localparam int POOL_KEYS = 56;
  localparam int FILL_BURST = 44;
  localparam int RANDOM_PER_PHASE = 270;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] key;
    logic        verdict;
  } cache_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = ACT_LOOKUP;
  logic [63:0] in_key = '0;
  logic        in_verdict = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;

  cache_req_t  pending_reqs[$];
  logic [1:0]  expected_status[$];

  logic [63:0] cache_keys[CACHE_ENTRIES];
  logic        cache_verdicts[CACHE_ENTRIES];
  int          cache_fill = 0;

  logic [63:0] key_pool[POOL_KEYS];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          errors = 0;

  lru_verdict_cache #(
    .CACHE_ENTRIES(CACHE_ENTRIES),
    .KEY_BITS(64)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_action(in_action),
    .in_key(in_key),
    .in_verdict(in_verdict),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status)
  );

  always #1 clk = ~clk;

  // returns the status seen before the item and updates the recency order
  function automatic logic [1:0] cache_apply(input cache_req_t req);
    int pos;
    int i;
    logic kept;
    logic [1:0] status;
    pos = -1;
    for (i = 0; i < cache_fill; i++) begin
      if (pos < 0 && cache_keys[i] == req.key) pos = i;
    end
    if (pos < 0) status = STAT_NONE;
    else status = cache_verdicts[pos] ? STAT_MISSING : STAT_VALID;
    if (req.action == ACT_INSERT) begin
      if (pos >= 0) begin
        kept = cache_verdicts[pos];
        for (i = pos; i < cache_fill - 1; i++) begin
          cache_keys[i] = cache_keys[i + 1];
          cache_verdicts[i] = cache_verdicts[i + 1];
        end
        cache_keys[cache_fill - 1] = req.key;
        cache_verdicts[cache_fill - 1] = kept;
      end else if (cache_fill < CACHE_ENTRIES) begin
        cache_keys[cache_fill] = req.key;
        cache_verdicts[cache_fill] = req.verdict;
        cache_fill++;
      end else begin
        for (i = 0; i < CACHE_ENTRIES - 1; i++) begin
          cache_keys[i] = cache_keys[i + 1];
          cache_verdicts[i] = cache_verdicts[i + 1];
        end
        cache_keys[CACHE_ENTRIES - 1] = req.key;
        cache_verdicts[CACHE_ENTRIES - 1] = req.verdict;
      end
    end else if (req.action == ACT_FLUSH) begin
      cache_fill = 0;
    end
    return status;
  endfunction

  // driver
  always @(posedge clk) begin
    cache_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_status.push_back(cache_apply({in_action, in_key, in_verdict}));
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_action <= req.action;
        in_key <= req.key;
        in_verdict <= req.verdict;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [1:0] want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          $error("status: no item expected, actual %0d", out_status);
          errors++;
        end else begin
          want = expected_status.pop_front();
          if (out_status !== want) begin
            $error("status: expected %0d, actual %0d", want, out_status);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  task automatic push_req(input logic [1:0] action, input logic [63:0] key, input logic verdict);
    pending_reqs.push_back('{action: action, key: key, verdict: verdict});
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_status.size() != 0);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct);
    int i;
    int r;
    logic [1:0] action;
    logic [63:0] key;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (i = 0; i < POOL_KEYS; i++) key_pool[i] = rand_key();
    // fill past capacity so the oldest entries get evicted
    push_req(ACT_FLUSH, key_pool[0], $urandom_range(1));
    for (i = 0; i < FILL_BURST; i++) push_req(ACT_INSERT, key_pool[i], $urandom_range(1));
    for (i = 0; i < RANDOM_PER_PHASE; i++) begin
      r = $urandom_range(199);
      if (r < 84) action = ACT_LOOKUP;
      else if (r < 186) action = ACT_INSERT;
      else if (r < 199) action = ACT_UNUSED;
      else action = ACT_FLUSH;
      if ($urandom_range(9) == 0) key = rand_key();
      else key = key_pool[$urandom_range(POOL_KEYS - 1)];
      push_req(action, key, $urandom_range(1));
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed items
    push_req(ACT_LOOKUP, 64'h0, 1'b0);
    push_req(ACT_INSERT, 64'h0, 1'b0);
    push_req(ACT_LOOKUP, 64'h0, 1'b1);
    push_req(ACT_INSERT, '1, 1'b1);
    push_req(ACT_LOOKUP, '1, 1'b0);
    push_req(ACT_INSERT, '1, 1'b0);
    push_req(ACT_LOOKUP, '1, 1'b1);
    push_req(ACT_INSERT, 64'h5555_5555_5555_5555, 1'b1);
    push_req(ACT_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    push_req(ACT_INSERT, 64'h0, 1'b1);
    push_req(ACT_LOOKUP, 64'h0, 1'b0);
    push_req(ACT_UNUSED, 64'h0, 1'b1);
    push_req(ACT_UNUSED, 64'h8000_0000_0000_0001, 1'b1);
    push_req(ACT_LOOKUP, 64'h8000_0000_0000_0001, 1'b0);
    push_req(ACT_LOOKUP, 64'haaaa_aaaa_aaaa_aaaa, 1'b1);
    push_req(ACT_LOOKUP, 64'h5555_5555_5555_5555, 1'b0);
    push_req(ACT_FLUSH, '1, 1'b1);
    push_req(ACT_LOOKUP, '1, 1'b0);
    push_req(ACT_FLUSH, 64'h1234_5678_9abc_def0, 1'b0);
    push_req(ACT_INSERT, 64'h1234_5678_9abc_def0, 1'b1);
    push_req(ACT_FLUSH, 64'h1234_5678_9abc_def0, 1'b0);

    run_phase(0, 0);
    run_phase(59, 0);
    run_phase(0, 59);
    run_phase(28, 28);

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
